// ===== rtl/rna_pkg.sv =====
// Package for the rational number ALU: command codes and width constants.
// No dependencies.
package rna_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int RNUM_W = 33;
  localparam int RDEN_W = 31;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4
  } cmd_t;
endpackage

// ===== rtl/rational_number_alu.sv =====
// Rational number ALU top level: sequencer around one shared multiplier,
// one shared adder and one bit-serial divider. Depends on rna_pkg.
//
// channel | direction | handshake          | payload
// request | in        | start && !busy     | command, a_numerator, a_denominator,
//         |           |                    | b_numerator, b_denominator
// result  | out       | done (one cycle)   | result_numerator, result_denominator,
//         |           |                    | less_flag, equal_flag, error_flag
//
// Sequence: 4 multiply steps, then Euclid GCD using the one 2W-bit restoring
// divider, then two more divisions by the gcd.
// Worst case is set by the number of Euclid steps, each a full division.
// Error transactions go straight to the output state; compares end after the multiply steps.
// rst is synchronous and returns the sequencer to idle. The receiver cannot stall.
module rational_number_alu #(
  parameter int OPERAND_WIDTH = rna_pkg::OPERAND_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic [2:0]                   command,
  input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
  input  logic [OPERAND_WIDTH-2:0]     a_denominator,
  input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
  input  logic [OPERAND_WIDTH-2:0]     b_denominator,
  output logic signed [rna_pkg::RNUM_W-1:0] result_numerator,
  output logic [rna_pkg::RDEN_W-1:0]   result_denominator,
  output logic                         less_flag,
  output logic                         equal_flag,
  output logic                         error_flag
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W + 1;          // product width, signed; the sum is one bit wider
  localparam int MW = 2 * W;              // magnitude width
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_COMB, S_GCD, S_GDIV, S_RN, S_RD, S_DIVQ, S_OUT
  } state_t;

  state_t state;
  logic [2:0] cmd;
  logic signed [W-1:0] an, bn;
  logic signed [W:0] ad, bd;
  logic signed [PW-1:0] p0, p1, dprod;
  logic signed [PW-1:0] mul_out;
  logic signed [W-1:0] mul_x;
  logic signed [W:0] mul_y;
  logic neg;
  logic [MW-1:0] mag, den, gx, gy, g;
  // shared divider
  logic [MW-1:0] dv_n, dv_d, dv_q, dv_r;
  logic [CW-1:0] dv_cnt;
  logic [MW:0] dv_trial;
  logic [1:0] phase; // what the current division is for

  always_comb begin
    unique case (state)
      S_M0:    begin mul_x = an; mul_y = bd; end
      S_M1:    begin mul_x = bn; mul_y = ad; end
      S_M2:    begin mul_x = an; mul_y = {bn[W-1], bn}; end
      default: begin
        // denominator: ad*bd, or ad*bn for divide
        mul_x = (cmd == rna_pkg::CMD_DIV) ? bn : $signed(bd[W-1:0]);
        mul_y = ad;
      end
    endcase
    mul_out = PW'(mul_x * mul_y);
  end

  assign dv_trial = {dv_r, dv_n[MW-1]} - {1'b0, dv_d};
  assign busy = (state != S_IDLE);

  logic signed [PW:0] sum;
  always_comb begin
    unique case (cmd)
      rna_pkg::CMD_SUB: sum = (PW+1)'(p0) - (PW+1)'(p1);
      default:          sum = (PW+1)'(p0) + (PW+1)'(p1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          cmd <= command;
          an <= a_numerator; bn <= b_numerator;
          ad <= {2'b0, a_denominator}; bd <= {2'b0, b_denominator};
          result_numerator <= '0; result_denominator <= '0;
          less_flag <= 1'b0; equal_flag <= 1'b0; error_flag <= 1'b0;
          if (command > rna_pkg::CMD_CMP || a_denominator == '0 || b_denominator == '0 ||
              (command == rna_pkg::CMD_DIV && b_numerator == '0)) begin
            error_flag <= 1'b1;
            state <= S_OUT;
          end else state <= S_M0;
        end
        S_M0: begin p0 <= mul_out; state <= S_M1; end
        S_M1: begin
          p1 <= mul_out;
          state <= S_M2;
        end
        S_M2: begin
          // multiply numerator an*bn
          if (cmd == rna_pkg::CMD_MUL) p0 <= mul_out;
          state <= S_M3;
        end
        S_M3: begin
          dprod <= mul_out;
          state <= S_COMB;
        end
        S_COMB: begin
          if (cmd == rna_pkg::CMD_CMP) begin
            less_flag <= (p0 < p1);
            equal_flag <= (p0 == p1);
            state <= S_OUT;
          end else begin
            logic signed [PW:0] n;
            logic dneg;
            n = (cmd == rna_pkg::CMD_ADD || cmd == rna_pkg::CMD_SUB) ? sum
                : (PW+1)'(p0);
            dneg = dprod[PW-1];
            if (dneg) n = -n;
            neg <= n[PW];
            mag <= MW'(n[PW] ? -n : n);
            den <= MW'(dneg ? -dprod : dprod);
            gx <= MW'(n[PW] ? -n : n);
            gy <= MW'(dneg ? -dprod : dprod);
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gx == '0) begin
            result_numerator <= '0;
            result_denominator <= rna_pkg::RDEN_W'(1);
            state <= S_OUT;
          end else if (gy == '0) begin
            g <= gx;
            dv_n <= mag; dv_d <= gx; dv_r <= '0; dv_cnt <= '0;
            phase <= 2'd1; state <= S_DIVQ;
          end else begin
            dv_n <= gx; dv_d <= gy; dv_r <= '0; dv_cnt <= '0;
            phase <= 2'd0; state <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (dv_cnt == CW'(MW)) begin
            unique case (phase)
              2'd0: begin gx <= gy; gy <= dv_r; state <= S_GCD; end
              2'd1: begin
                result_numerator <= neg ? -rna_pkg::RNUM_W'(dv_q)
                                        : rna_pkg::RNUM_W'(dv_q);
                dv_n <= den; dv_d <= g; dv_r <= '0; dv_cnt <= '0;
                phase <= 2'd2;
              end
              default: begin
                result_denominator <= rna_pkg::RDEN_W'(dv_q);
                state <= S_OUT;
              end
            endcase
          end else begin
            dv_n <= {dv_n[MW-2:0], 1'b0};
            if (!dv_trial[MW]) begin
              dv_r <= dv_trial[MW-1:0]; dv_q <= {dv_q[MW-2:0], 1'b1};
            end else begin
              dv_r <= {dv_r[MW-2:0], dv_n[MW-1]}; dv_q <= {dv_q[MW-2:0], 1'b0};
            end
            dv_cnt <= dv_cnt + 1'b1;
          end
        end
        S_OUT: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(error_flag && (less_flag || equal_flag))) else $error("flag clash");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && error_flag) |-> (result_denominator == '0)) else $error("err den");
  a_cmp_den: assert property (@(posedge clk) disable iff (rst)
    (done && !error_flag && cmd != rna_pkg::CMD_CMP) |-> (result_denominator != '0))
    else $error("zero den");
endmodule

// ===== verif/rna_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the rational number ALU: predicts each accepted transaction
// and compares every done strobe against the oldest prediction. Uses rna_pkg.
module rna_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        done,
  input  logic [2:0]                  command,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_numerator,
  input  logic [rna_pkg::OPERAND_WIDTH-2:0]    a_denominator,
  input  logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_numerator,
  input  logic [rna_pkg::OPERAND_WIDTH-2:0]    b_denominator,
  input  logic signed [rna_pkg::RNUM_W-1:0]    result_numerator,
  input  logic [rna_pkg::RDEN_W-1:0]           result_denominator,
  input  logic                        less_flag,
  input  logic                        equal_flag,
  input  logic                        error_flag,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count,
  output int                          error_count,
  output int                          compare_count
);

  typedef struct packed {
    logic signed [rna_pkg::RNUM_W-1:0] num;
    logic [rna_pkg::RDEN_W-1:0]        den;
    logic                     less;
    logic                     equal;
    logic                     err;
  } fraction_result_t;

  fraction_result_t expected_fractions[$];

  function automatic fraction_result_t reduce_fraction(
      logic [2:0] cmd, longint an, longint ad, longint bn, longint bd);
    fraction_result_t r;
    longint n, d, x, y, t;
    r = '0;
    if (cmd > rna_pkg::CMD_CMP || ad == 0 || bd == 0 ||
        (cmd == rna_pkg::CMD_DIV && bn == 0)) begin
      r.err = 1'b1;
      return r;
    end
    d = ad * bd;
    case (cmd)
      rna_pkg::CMD_ADD: n = an * bd + bn * ad;
      rna_pkg::CMD_SUB: n = an * bd - bn * ad;
      rna_pkg::CMD_MUL: n = an * bn;
      rna_pkg::CMD_DIV: begin
        n = an * bd;
        d = ad * bn;
        if (d < 0) begin
          d = -d;
          n = -n;
        end
      end
      default: begin
        r.less  = (an * bd) < (bn * ad);
        r.equal = (an * bd) == (bn * ad);
        return r;
      end
    endcase
    if (n == 0) begin
      r.den = rna_pkg::RDEN_W'(1);
      return r;
    end
    // Euclid on magnitudes; n/g keeps the sign
    x = (n < 0) ? -n : n;
    y = d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    r.num = rna_pkg::RNUM_W'(n / x);
    r.den = rna_pkg::RDEN_W'(d / x);
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_result_t got, exp_r;
    if (rst) begin
      fail_count    <= 0;
      result_count  <= 0;
      error_count   <= 0;
      compare_count <= 0;
      pending       <= 0;
      expected_fractions.delete();
    end else begin
      if (start && !busy) begin
        expected_fractions.push_back(reduce_fraction(command, a_numerator, a_denominator,
                                                     b_numerator, b_denominator));
        if (command == rna_pkg::CMD_CMP) compare_count <= compare_count + 1;
      end
      if (done) begin
        got = '{result_numerator, result_denominator, less_flag, equal_flag, error_flag};
        result_count <= result_count + 1;
        if (error_flag) error_count <= error_count + 1;
        if (expected_fractions.size() == 0) begin
          $display("%0t: result with no transaction outstanding: %0d/%0d l%b e%b err%b",
                   $time, got.num, got.den, got.less, got.equal, got.err);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_fractions.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch exp %0d/%0d less %b equal %b error %b",
                     $time, exp_r.num, exp_r.den, exp_r.less, exp_r.equal, exp_r.err);
            $display("%0t:          got %0d/%0d less %b equal %b error %b",
                     $time, got.num, got.den, got.less, got.equal, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_fractions.size();
    end
  end

endmodule

// ===== verif/rational_number_alu_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for rational_number_alu: drives bursts of fraction transactions
// and reports the verdict. Depends on rna_pkg, rna_checker and the RTL.
module rational_number_alu_tb;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1280;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] command = rna_pkg::CMD_ADD;
  logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_numerator = '0;
  logic [rna_pkg::OPERAND_WIDTH-2:0] a_denominator = 1;
  logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_numerator = '0;
  logic [rna_pkg::OPERAND_WIDTH-2:0] b_denominator = 1;
  logic busy, done, less_flag, equal_flag, error_flag;
  logic signed [rna_pkg::RNUM_W-1:0] result_numerator;
  logic [rna_pkg::RDEN_W-1:0] result_denominator;
  int fail_count, pending, result_count, error_count, compare_count;

  always #1 clk = ~clk;

  rational_number_alu i_dut (.*);
  rna_checker i_checker (.*);

  initial begin
    #40_000_000;
    $display("timeout");
    $display("rational_number_alu_tb failed");
    $finish;
  end

  // drive one transaction; returns after the edge that accepts it
  task automatic issue(logic [2:0] cmd, logic signed [15:0] an, logic [14:0] ad,
                       logic signed [15:0] bn, logic [14:0] bd);
    command       <= cmd;
    a_numerator   <= an;
    a_denominator <= ad;
    b_numerator   <= bn;
    b_denominator <= bd;
    start         <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // pending is registered, so wait for the next edge before trusting it
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_numerator();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
    endcase
  endfunction

  function automatic logic [14:0] pick_denominator();
    case ($urandom_range(0, 3))
      0: return 15'($urandom_range(1, 32767));
      1: return 15'($urandom_range(1, 24));
      2: return $urandom_range(0, 1) ? 15'h7fff : 15'd1;
      default: return 15'($urandom_range(1, 400));
    endcase
  endfunction

  initial begin
    int burst_left;
    logic [2:0] cmd;
    logic [14:0] ad, bd;
    logic signed [15:0] an, bn;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, each command, error cases, sign and reduction cases
    issue(rna_pkg::CMD_ADD, 16'sh7fff, 15'h7fff, 16'sh7fff, 15'h7fff);
    issue(rna_pkg::CMD_ADD, 16'sh8000, 15'h7fff, 16'sh8000, 15'h7ffe);
    issue(rna_pkg::CMD_SUB, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
    issue(rna_pkg::CMD_SUB, 16'sh8000, 15'h7fff, 16'sh7fff, 15'd1);
    issue(rna_pkg::CMD_SUB, 16'sd3, 15'd4, 16'sd6, 15'd8);
    issue(rna_pkg::CMD_MUL, 16'sh8000, 15'd1, 16'sh8000, 15'd1);
    issue(rna_pkg::CMD_MUL, 16'sh8000, 15'h7fff, 16'sh7fff, 15'h7fff);
    issue(rna_pkg::CMD_MUL, 16'sd0, 15'd5, 16'sd7, 15'd9);
    issue(rna_pkg::CMD_DIV, 16'sd1, 15'd2, -16'sd3, 15'd4);
    issue(rna_pkg::CMD_DIV, 16'sh8000, 15'd1, 16'sh8000, 15'h7fff);
    issue(rna_pkg::CMD_DIV, 16'sd5, 15'd3, 16'sd0, 15'd7);
    issue(rna_pkg::CMD_DIV, 16'sd0, 15'd3, -16'sd1, 15'd7);
    issue(rna_pkg::CMD_CMP, 16'sd1, 15'd2, 16'sd2, 15'd4);
    issue(rna_pkg::CMD_CMP, -16'sd1, 15'd2, 16'sd1, 15'd3);
    issue(rna_pkg::CMD_CMP, 16'sh7fff, 15'd1, 16'sh8000, 15'd1);
    issue(rna_pkg::CMD_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1);
    issue(rna_pkg::CMD_CMP, 16'sd1, 15'd1, 16'sd1, 15'd0);
    issue(CMD_UNUSED_LO, 16'sd1, 15'd1, 16'sd1, 15'd1);
    issue(CMD_UNUSED_MID, -16'sd1, 15'd3, 16'sd2, 15'd5);
    issue(CMD_UNUSED_HI, 16'sh7fff, 15'h7fff, 16'sh8000, 15'h7fff);
    issue(rna_pkg::CMD_ADD, 16'sd1, 15'd2, -16'sd1, 15'd2);
    issue(rna_pkg::CMD_SUB, 16'sd55, 15'd89, 16'sd34, 15'd55);

    // hold off until the block has drained
    start <= 1'b0;
    drain();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
        if (i == RANDOM_ITEMS / 2) drain();
      end
      burst_left--;
      cmd = $urandom_range(0, 40) == 0 ? 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))
                                       : 3'($urandom_range(rna_pkg::CMD_ADD,
                                                           rna_pkg::CMD_CMP));
      an = pick_numerator();
      bn = pick_numerator();
      ad = $urandom_range(0, 50) == 0 ? 15'd0 : pick_denominator();
      bd = $urandom_range(0, 50) == 0 ? 15'd0 : pick_denominator();
      // scaled copies make equal values likely in compares
      if (cmd == rna_pkg::CMD_CMP && $urandom_range(0, 2) == 0) begin
        an = $signed(16'($urandom_range(0, 200))) - 16'sd100;
        ad = 15'($urandom_range(1, 100));
        bd = ad * 15'($urandom_range(1, 9));
        bn = an * $signed(16'(bd / ad));
      end
      issue(cmd, an, ad, bn, bd);
    end
    start <= 1'b0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: %0d compares, %0d error results",
             result_count, compare_count, error_count);
    if (fail_count == 0) begin
      $display("rational_number_alu_tb passed");
    end else begin
      $display("rational_number_alu_tb failed");
    end
    $finish;
  end

endmodule
